// ===== hdl/tccs_pkg.sv =====
// ============================================================================
// tccs_pkg: shared constants and types for the text console
// Field widths, character codes, register map and command codes used by the
// console controller, its screen store and its port checker.
// ============================================================================
package tccs_pkg;

    // Default screen geometry
    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;

    // Port field widths
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int ADDR_IN_W   = 11;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 5;
    localparam int LIN_OUT_W   = 11;
    localparam int EXT_W       = 16;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;   // word index carried by paddr[2]

    // Character codes and reset attribute
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

endpackage

// ===== hdl/tccs_screen_mem.sv =====
// ============================================================================
// tccs_screen_mem: character-cell screen store
// Single write port, single read port with registered read data.
// ============================================================================
module tccs_screen_mem #(
    parameter int DEPTH = tccs_pkg::SCREEN_COLS_DEF * tccs_pkg::SCREEN_ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tccs_pkg::CELL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tccs_pkg::CELL_W-1:0] o_rdata
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/text_console_cursor_scroll.sv =====
// ============================================================================
// text_console_cursor_scroll: text console controller with scrolling
// Cursor tracking, character writes, row scroll and cell reads over a
// character-cell screen store, run by a small sequencer.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per
//   transaction: push a character (i_command = 0) or read one cell
//   (i_command = 1, i_cell_address). Output channel (o_out_valid /
//   i_out_stall) returns one transaction per command: the cell read (0 on a
//   push) plus the cursor column, row and linear position after the command.
//   The attribute byte for written and blanked cells sits in an APB register
//   at byte address 0 (reset 0x07); write it only while the console is idle.
// Sequencing (the screen store serves one access at a time):
//   plain character: S_WRITE, then S_DONE; read: S_READ, then S_DONE;
//   newline without scroll: straight to S_DONE;
//   scroll (newline or wrap on the last row): a read and a write state per
//   moved cell, then a blank write for each cell of the last row,
//   then S_WRITE when a character is written after the wrap.
//   o_in_stall is high from acceptance until the result is loaded.
// Reset: the store is swept to blank cells in attribute 0x07, one cell per
//   cycle; input stays stalled meanwhile.
// Receiver stall: the result register holds; the next command is still
//   accepted and its result waits until the register frees up.
// ============================================================================
module text_console_cursor_scroll #(
    parameter int SCREEN_COLS = tccs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tccs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [tccs_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tccs_pkg::ADDR_IN_W-1:0] i_cell_address,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tccs_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tccs_pkg::COL_OUT_W-1:0] o_cursor_col,
    output logic [tccs_pkg::ROW_OUT_W-1:0] o_cursor_row,
    output logic [tccs_pkg::LIN_OUT_W-1:0] o_cursor_linear,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tccs_pkg::PADDR_W-1:0]   paddr,
    input  logic [tccs_pkg::PDATA_W-1:0]   pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import tccs_pkg::*;

    localparam int CELLS         = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW            = $clog2(CELLS);
    localparam int CW            = $clog2(SCREEN_COLS + 1);
    localparam int RW            = $clog2(SCREEN_ROWS);
    localparam int LW            = $clog2(CELLS + 1);
    localparam int LAST_ROW_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_BLANK,
        S_WRITE,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [LW-1:0]       r_lin, n_lin;
    logic                r_wr_pend, n_wr_pend;
    logic [ATTR_W-1:0]   r_attr, n_attr;
    logic [CHAR_W-1:0]   r_code, n_code;
    logic [CELL_W-1:0]   r_data, n_data;
    logic                r_in_range, n_in_range;
    logic                r_out_valid, n_out_valid;
    logic [CELL_W-1:0]   r_out_data, n_out_data;
    logic [COL_OUT_W-1:0] r_out_col, n_out_col;
    logic [ROW_OUT_W-1:0] r_out_row, n_out_row;
    logic [LIN_OUT_W-1:0] r_out_lin, n_out_lin;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [CELL_W-1:0]   w_wdata;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic [CELL_W-1:0]   w_rdata;

    logic                w_newline;
    logic                w_wrap;
    logic                w_last_row;
    logic                w_last_cell;
    logic                w_cfg_wr;
    logic [EXT_W-1:0]    w_col_ext;
    logic [EXT_W-1:0]    w_row_ext;
    logic [EXT_W-1:0]    w_lin_ext;

    tccs_screen_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_newline   = (i_char_code == NEWLINE_CODE);
    // wrap only when the column has run up to the width
    assign w_wrap      = !w_newline && (r_col == CW'(SCREEN_COLS));
    assign w_last_row  = (r_row == RW'(SCREEN_ROWS - 1));
    assign w_last_cell = (r_ptr == AW'(CELLS - 1));
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    // fit cursor values to the fixed port widths
    assign w_col_ext   = EXT_W'(r_col);
    assign w_row_ext   = EXT_W'(r_row);
    assign w_lin_ext   = EXT_W'(r_lin);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_col       = r_col;
        n_row       = r_row;
        n_lin       = r_lin;
        n_wr_pend   = r_wr_pend;
        n_attr      = r_attr;
        n_code      = r_code;
        n_data      = r_data;
        n_in_range  = r_in_range;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_lin   = r_out_lin;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = '0;

        // register write lands at any time; the sweep uses the reset attribute
        if (w_cfg_wr && (paddr[2] == REG_TEXT_ATTR)) begin
            n_attr = pwdata[ATTR_W-1:0];
        end

        // drop the result once the receiver takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = {ATTR_RESET, BLANK_CODE};
                if (w_last_cell) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_code    = i_char_code;
                    n_data    = '0;
                    n_wr_pend = 1'b0;
                    if (i_command == CMD_READ) begin
                        w_re       = 1'b1;
                        w_raddr    = AW'(i_cell_address);
                        n_in_range = (EXT_W'(i_cell_address) < EXT_W'(CELLS));
                        n_state    = S_READ;
                    end else if (w_newline || w_wrap) begin
                        n_col     = '0;
                        n_wr_pend = w_wrap;
                        if (w_last_row) begin
                            // scroll: cursor parks at the start of the last row
                            n_lin   = LW'(LAST_ROW_BASE);
                            n_ptr   = AW'(SCREEN_COLS);
                            n_state = S_SCROLL_RD;
                        end else begin
                            n_row   = r_row + RW'(1);
                            n_lin   = r_lin + LW'(SCREEN_COLS) - LW'(r_col);
                            n_state = w_wrap ? S_WRITE : S_DONE;
                        end
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_READ: begin
                n_data  = r_in_range ? w_rdata : '0;
                n_state = S_DONE;
            end
            S_SCROLL_RD: begin
                w_re    = 1'b1;
                w_raddr = r_ptr;
                n_state = S_SCROLL_WR;
            end
            S_SCROLL_WR: begin
                // move the cell up one row
                w_we    = 1'b1;
                w_waddr = r_ptr - AW'(SCREEN_COLS);
                w_wdata = w_rdata;
                if (w_last_cell) begin
                    n_ptr   = AW'(LAST_ROW_BASE);
                    n_state = S_BLANK;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_SCROLL_RD;
                end
            end
            S_BLANK: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = {r_attr, BLANK_CODE};
                if (w_last_cell) begin
                    n_ptr   = '0;
                    n_state = r_wr_pend ? S_WRITE : S_DONE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_WRITE: begin
                w_we      = 1'b1;
                w_waddr   = r_lin[AW-1:0];
                w_wdata   = {r_attr, r_code};
                n_col     = r_col + CW'(1);
                n_lin     = r_lin + LW'(1);
                n_wr_pend = 1'b0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data;
                    n_out_col   = w_col_ext[COL_OUT_W-1:0];
                    n_out_row   = w_row_ext[ROW_OUT_W-1:0];
                    n_out_lin   = w_lin_ext[LIN_OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_lin       <= '0;
            r_wr_pend   <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_lin       <= n_lin;
            r_wr_pend   <= n_wr_pend;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
        r_code     <= n_code;
        r_data     <= n_data;
        r_in_range <= n_in_range;
        r_out_data <= n_out_data;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_lin  <= n_out_lin;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cell_data     = r_out_data;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_linear = r_out_lin;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? PDATA_W'(r_attr) : '0;

endmodule

// ===== hdl/tccs_checker.sv =====
// ============================================================================
// tccs_checker: port-level checks for the text console
// Watches the result channel for handshake hold and cursor consistency.
// ============================================================================
module tccs_checker #(
    parameter int SCREEN_COLS = tccs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tccs_pkg::SCREEN_ROWS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [tccs_pkg::CELL_W-1:0]    o_cell_data,
    input logic [tccs_pkg::COL_OUT_W-1:0] o_cursor_col,
    input logic [tccs_pkg::ROW_OUT_W-1:0] o_cursor_row,
    input logic [tccs_pkg::LIN_OUT_W-1:0] o_cursor_linear
);
    import tccs_pkg::*;

    // cursor fields are exact only when the geometry fits the port widths
    localparam bit FITS = (SCREEN_COLS < (1 << COL_OUT_W)) &&
                          (SCREEN_ROWS <= (1 << ROW_OUT_W));

    logic [31:0] w_lin_calc;
    assign w_lin_calc = 32'(o_cursor_row) * 32'(SCREEN_COLS) + 32'(o_cursor_col);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_cell_data) && $stable(o_cursor_linear))
        else $error("result payload changed while stalled");

    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && FITS |-> o_cursor_linear == w_lin_calc[LIN_OUT_W-1:0])
        else $error("linear cursor disagrees with row and column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && FITS |-> 32'(o_cursor_col) <= 32'(SCREEN_COLS))
        else $error("cursor column beyond width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && FITS |-> 32'(o_cursor_row) < 32'(SCREEN_ROWS))
        else $error("cursor row beyond last row");

endmodule

bind text_console_cursor_scroll tccs_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tccs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_cell_data     (o_cell_data),
    .o_cursor_col    (o_cursor_col),
    .o_cursor_row    (o_cursor_row),
    .o_cursor_linear (o_cursor_linear)
);
